// ----- rtl/core/lbd_pkg.sv -----
`timescale 1ns / 1ps
package lbd_pkg;

  // Internal widths are sized for the longest line the block supports.
  localparam int IDX_W      = 17;
  localparam int WSUM_W     = 32;
  localparam int MSUM_W     = 48;
  localparam int NUM_W      = MSUM_W + 2;
  localparam int QUO_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_ONLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_SCALE = 3'd5;

  localparam logic [15:0]      THRESHOLD_RESET = 16'd6554;
  localparam logic [12:0]      SCALE_DEFAULT   = 13'd400;
  localparam logic [QUO_W-1:0] MORPH_ONE       = 17'd65536;
  localparam logic [6:0]       COUNT_MAX       = 7'd127;

  typedef struct packed {
    logic        enable;
    logic        focus_only;
    logic [15:0] amp_threshold;
    logic [12:0] min_blob_width;
    logic [12:0] max_merge_gap;
    logic [12:0] morph_scale;
  } lbd_cfg_t;

  typedef struct packed {
    logic              is_summary;
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  stop;
    logic [15:0]       peak;
    logic [IDX_W-1:0]  width;
    logic [WSUM_W-1:0] weight;
    logic [MSUM_W-1:0] moment;
    logic [6:0]        count;
    logic [IDX_W-1:0]  widest;
    logic              morph_en;
    logic [12:0]       scale;
  } lbd_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } lbd_bk_state_t;

endpackage

// ----- rtl/core/line_blob_detector_unit.sv -----
`timescale 1ns / 1ps
// Path: a blob or a divided summary goes through the job queue and the serial divider
// to the result ports; a summary with no morph division skips the divider, and one
// queued behind a blob from the same item waits until that blob is popped.
// Throughput: the front takes one item per cycle while the job queue has two free slots;
// the back handles one job at a time: load, 17 steps on a divided result, then pop.
// Reset (sync, rst_n low) clears line state and queue, presets config; no clearing pass.
module line_blob_detector_unit #(
  parameter int MAX_RUNS   = 64,
  parameter int LINE_NOTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_amplitude,
  input  logic        in_line_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_is_summary,
  output logic [11:0] out_blob_start,
  output logic [12:0] out_blob_end,
  output logic [11:0] out_blob_center,
  output logic [15:0] out_blob_peak,
  output logic [12:0] out_blob_width,
  output logic [6:0]  out_line_blob_count,
  output logic [16:0] out_morph,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbd_pkg::*;

  // Register file. Writes are only expected while the block is idle.
  lbd_cfg_t cfg_r;
  lbd_job_t job0, job1, jq;
  logic     push0, push1, room2, jq_empty, jq_pop, accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  // The front may emit a blob and a summary for one item, so it needs two free slots.
  assign in_full   = !room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.focus_only     <= 1'b0;
      cfg_r.amp_threshold  <= THRESHOLD_RESET;
      cfg_r.min_blob_width <= 13'd1;
      cfg_r.max_merge_gap  <= '0;
      cfg_r.morph_scale    <= SCALE_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:      cfg_r.enable         <= cfg_data[0];
        REG_FOCUS_ONLY:  cfg_r.focus_only     <= cfg_data[0];
        REG_THRESHOLD:   cfg_r.amp_threshold  <= cfg_data;
        REG_MIN_WIDTH:   cfg_r.min_blob_width <= cfg_data[12:0];
        REG_MERGE_GAP:   cfg_r.max_merge_gap  <= cfg_data[12:0];
        REG_MORPH_SCALE: cfg_r.morph_scale    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Front end: run tracking, merging, blob qualification; one item per cycle if not full.
  lbd_front #(.MAX_RUNS(MAX_RUNS), .LINE_NOTES(LINE_NOTES)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .accept(accept),
    .amplitude(in_amplitude), .line_end(in_line_end),
    .push0(push0), .push1(push1), .job0(job0), .job1(job1)
  );

  // Short queue of finished blobs and summaries awaiting the back end.
  lbd_jobq u_jobq (
    .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1), .d0(job0), .d1(job1),
    .pop(jq_pop), .q(jq), .empty(jq_empty), .room2(room2)
  );

  // Back end: serial divider for the centroid and morph, holding the result register.
  lbd_back u_back (
    .clk(clk), .rst_n(rst_n), .job(jq), .job_empty(jq_empty), .job_pop(jq_pop),
    .out_empty(out_empty), .out_pop(out_pop), .out_is_summary(out_is_summary),
    .out_blob_start(out_blob_start), .out_blob_end(out_blob_end),
    .out_blob_center(out_blob_center), .out_blob_peak(out_blob_peak),
    .out_blob_width(out_blob_width), .out_line_blob_count(out_line_blob_count),
    .out_morph(out_morph), .out_last(out_last)
  );

endmodule

// ----- rtl/core/lbd_front.sv -----
`timescale 1ns / 1ps
module lbd_front #(
  parameter int MAX_RUNS   = 64,
  parameter int LINE_NOTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lbd_pkg::lbd_cfg_t cfg,
  input  logic              accept,
  input  logic [15:0]       amplitude,
  input  logic              line_end,
  output logic              push0,
  output logic              push1,
  output lbd_pkg::lbd_job_t job0,
  output lbd_pkg::lbd_job_t job1
);
  import lbd_pkg::*;

  localparam int RC_W = $clog2(MAX_RUNS + 1);
  localparam logic [RC_W-1:0]  RUNS_CAP = RC_W'(MAX_RUNS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_NOTES - 1);

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_run_r, in_run_nxt;
  logic [RC_W-1:0]   runs_r, runs_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pstart_r, pstart_nxt, pend_end_r, pend_end_nxt;
  logic [IDX_W-1:0]  gap_r, gap_nxt;
  logic [WSUM_W-1:0] wsum_r, wsum_nxt, gwsum_r, gwsum_nxt;
  logic [MSUM_W-1:0] msum_r, msum_nxt, gmsum_r, gmsum_nxt;
  logic [15:0]       peak_r, peak_nxt;
  logic [6:0]        count_r, count_nxt;
  logic [IDX_W-1:0]  widest_r, widest_nxt;

  always_comb begin
    logic              is_end;
    logic              rel;
    logic              keep;
    logic [IDX_W-1:0]  bw;
    logic [MSUM_W-1:0] prod;
    lbd_job_t          blob;
    lbd_job_t          summ;
    idx_nxt = idx_r; in_run_nxt = in_run_r; runs_nxt = runs_r; pend_nxt = pend_r;
    pstart_nxt = pstart_r; pend_end_nxt = pend_end_r; gap_nxt = gap_r;
    wsum_nxt = wsum_r; msum_nxt = msum_r; gwsum_nxt = gwsum_r; gmsum_nxt = gmsum_r;
    peak_nxt = peak_r; count_nxt = count_r; widest_nxt = widest_r;
    rel = 1'b0;
    keep = 1'b0;
    bw = '0;
    blob = '0;
    summ = '0;
    push0 = 1'b0;
    push1 = 1'b0;
    is_end = line_end || (idx_r >= LAST_IDX);
    prod = MSUM_W'(amplitude) * MSUM_W'(idx_r);

    if (runs_r < RUNS_CAP) begin
      if (amplitude >= cfg.amp_threshold) begin
        if (!in_run_r) begin
          if (pend_r) begin
            wsum_nxt = wsum_r + gwsum_r;
            msum_nxt = msum_r + gmsum_r;
          end else begin
            pend_nxt = 1'b1;
            pstart_nxt = idx_r;
            wsum_nxt = '0;
            msum_nxt = '0;
            peak_nxt = '0;
          end
          in_run_nxt = 1'b1;
        end
        wsum_nxt = wsum_nxt + WSUM_W'(amplitude);
        msum_nxt = msum_nxt + prod;
        if (amplitude > peak_nxt) peak_nxt = amplitude;
        pend_end_nxt = idx_r + 1'b1;
      end else begin
        if (in_run_r) begin
          in_run_nxt = 1'b0;
          runs_nxt = runs_r + 1'b1;
          gap_nxt = '0;
          gwsum_nxt = '0;
          gmsum_nxt = '0;
        end
        if (pend_r) begin
          gap_nxt = gap_nxt + 1'b1;
          gwsum_nxt = gwsum_nxt + WSUM_W'(amplitude);
          gmsum_nxt = gmsum_nxt + prod;
          if (gap_nxt > IDX_W'(cfg.max_merge_gap)) rel = 1'b1;
        end
      end
    end
    idx_nxt = idx_r + 1'b1;

    // A blob leaves either on the gap that breaks it or at line end.
    if (is_end) begin
      in_run_nxt = 1'b0;
      if (pend_nxt) rel = 1'b1;
    end
    if (rel) begin
      pend_nxt = 1'b0;
      bw = pend_end_nxt - pstart_nxt;
      keep = cfg.enable && (bw >= IDX_W'(cfg.min_blob_width));
      blob.start  = pstart_nxt;
      blob.stop   = pend_end_nxt;
      blob.peak   = peak_nxt;
      blob.width  = bw;
      blob.weight = wsum_nxt;
      blob.moment = msum_nxt;
      if (keep) begin
        if (count_nxt < COUNT_MAX) count_nxt = count_nxt + 1'b1;
        if (bw > widest_nxt) widest_nxt = bw;
      end
    end
    summ.is_summary = 1'b1;
    summ.count      = count_nxt;
    summ.widest     = widest_nxt;
    summ.morph_en   = cfg.enable && !cfg.focus_only && (count_nxt != '0);
    summ.scale      = (cfg.morph_scale != '0) ? cfg.morph_scale : SCALE_DEFAULT;

    if (keep) begin
      job0 = blob;
      job1 = summ;
      push0 = accept;
      push1 = accept && is_end;
    end else begin
      job0 = summ;
      job1 = summ;
      push0 = accept && is_end;
    end

    if (is_end) begin
      idx_nxt = '0; in_run_nxt = 1'b0; runs_nxt = '0; pend_nxt = 1'b0;
      pstart_nxt = '0; pend_end_nxt = '0; gap_nxt = '0;
      wsum_nxt = '0; msum_nxt = '0; gwsum_nxt = '0; gmsum_nxt = '0;
      peak_nxt = '0; count_nxt = '0; widest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; in_run_r <= 1'b0; runs_r <= '0; pend_r <= 1'b0;
      pstart_r <= '0; pend_end_r <= '0; gap_r <= '0;
      wsum_r <= '0; msum_r <= '0; gwsum_r <= '0; gmsum_r <= '0;
      peak_r <= '0; count_r <= '0; widest_r <= '0;
    end else if (accept) begin
      idx_r <= idx_nxt; in_run_r <= in_run_nxt; runs_r <= runs_nxt; pend_r <= pend_nxt;
      pstart_r <= pstart_nxt; pend_end_r <= pend_end_nxt; gap_r <= gap_nxt;
      wsum_r <= wsum_nxt; msum_r <= msum_nxt; gwsum_r <= gwsum_nxt; gmsum_r <= gmsum_nxt;
      peak_r <= peak_nxt; count_r <= count_nxt; widest_r <= widest_nxt;
    end
  end

endmodule

// ----- rtl/core/lbd_jobq.sv -----
`timescale 1ns / 1ps
module lbd_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic              push1,
  input  lbd_pkg::lbd_job_t d0,
  input  lbd_pkg::lbd_job_t d1,
  input  logic              pop,
  output lbd_pkg::lbd_job_t q,
  output logic              empty,
  output logic              room2
);
  import lbd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  lbd_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]   wp1;

  assign wp1   = wp_r + 1'b1;
  assign q     = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign room2 = (cnt_r <= (PW + 1)'(DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PW'(push0) + PW'(push1);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + (PW + 1)'(push0) + (PW + 1)'(push1) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) mem_r[wp_r] <= d0;
    if (push1) mem_r[wp1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/lbd_back.sv -----
`timescale 1ns / 1ps
module lbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lbd_pkg::lbd_job_t job,
  input  logic              job_empty,
  output logic              job_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_is_summary,
  output logic [11:0]       out_blob_start,
  output logic [12:0]       out_blob_end,
  output logic [11:0]       out_blob_center,
  output logic [15:0]       out_blob_peak,
  output logic [12:0]       out_blob_width,
  output logic [6:0]        out_line_blob_count,
  output logic [16:0]       out_morph,
  output logic              out_last
);
  import lbd_pkg::*;

  lbd_bk_state_t    state_r, state_nxt;
  lbd_job_t         job_r;
  logic [NUM_W-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             load;

  always_comb begin
    logic [NUM_W-1:0] diff;
    logic             ge;
    logic [IDX_W:0]   mid;
    state_nxt = state_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    load = 1'b0;
    diff = rem_r - dsh_r;
    ge = (rem_r >= dsh_r);
    mid = ({1'b0, job.start} + {1'b0, job.stop}) >> 1;
    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          load = 1'b1;
          cnt_nxt = 5'(QUO_W - 1);
          quo_nxt = '0;
          if (job.is_summary) begin
            rem_nxt = NUM_W'(job.widest) << 16;
            dsh_nxt = NUM_W'(job.scale) << 16;
            if (!job.morph_en) begin
              state_nxt = BK_OUT;
            end else if (NUM_W'(job.widest) >= (NUM_W'(job.scale) << 1)) begin
              quo_nxt = MORPH_ONE;
              state_nxt = BK_OUT;
            end else begin
              state_nxt = BK_DIV;
            end
          end else begin
            rem_nxt = (NUM_W'(job.moment) << 1) + NUM_W'(job.weight);
            dsh_nxt = NUM_W'(job.weight) << (QUO_W);
            if (job.weight == '0) begin
              quo_nxt = QUO_W'(mid);
              state_nxt = BK_OUT;
            end else begin
              state_nxt = BK_DIV;
            end
          end
        end
      end
      BK_DIV: begin
        if (ge) rem_nxt = diff;
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_OUT;
          if (job_r.is_summary && ({quo_r[QUO_W-2:0], ge} > MORPH_ONE)) quo_nxt = MORPH_ONE;
        end
      end
      BK_OUT: begin
        if (out_pop) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign job_pop   = load;
  assign out_empty = (state_r != BK_OUT);

  always_comb begin
    out_is_summary      = job_r.is_summary;
    out_last            = job_r.is_summary;
    out_blob_start      = job_r.is_summary ? '0 : job_r.start[11:0];
    out_blob_end        = job_r.is_summary ? '0 : job_r.stop[12:0];
    out_blob_width      = job_r.is_summary ? '0 : job_r.width[12:0];
    out_blob_peak       = job_r.is_summary ? '0 : job_r.peak;
    out_blob_center     = job_r.is_summary ? '0 : quo_r[11:0];
    out_line_blob_count = job_r.is_summary ? job_r.count : '0;
    out_morph           = job_r.is_summary ? quo_r : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
      // The blob divisor is doubled for rounding; the first step uses bit QUO_W-1.
      if (!job.is_summary) dsh_r <= NUM_W'(job.weight) << QUO_W;
      else dsh_r <= dsh_nxt;
    end else begin
      dsh_r <= dsh_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- rtl/core/lbd_checker.sv -----
`timescale 1ns / 1ps
module lbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_is_summary,
  input logic        out_last,
  input logic [11:0] out_blob_start,
  input logic [12:0] out_blob_end,
  input logic [12:0] out_blob_width,
  input logic [16:0] out_morph
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_blob_end) && $stable(out_morph)))
    else $error("held result changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last == out_is_summary))
    else $error("last flag does not match summary");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_summary) |->
      (out_blob_width == out_blob_end - {1'b0, out_blob_start}))
    else $error("blob width inconsistent");

  a_morph: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_morph <= 17'd65536))
    else $error("morph above one");

endmodule

bind line_blob_detector_unit lbd_checker u_lbd_checker (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_is_summary(out_is_summary), .out_last(out_last),
  .out_blob_start(out_blob_start), .out_blob_end(out_blob_end),
  .out_blob_width(out_blob_width), .out_morph(out_morph)
);
